// ===== hdl/zip_stored_entry_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer assertion macros
// Implication checks on a named clock and reset, switched off for synthesis.
// ----------------------------------------------------------------------------
`ifndef ZIP_STORED_ENTRY_DEFRAMER_MACROS_SVH
`define ZIP_STORED_ENTRY_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define ZSED_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zsed check failed");
`define ZSED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zsed check failed");
`else
`define ZSED_ASSERT_SAME(label, clk, rst, ante, cons)
`define ZSED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/zsed_pkg.sv =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer package
// Shared codes, constants and the structs passed between the modules.
// ----------------------------------------------------------------------------
package zsed_pkg;

   localparam logic [31:0] SigLocal       = 32'h04034B50;
   localparam logic [31:0] SigCentral     = 32'h02014B50;
   localparam logic [31:0] SigEnd         = 32'h06054B50;
   localparam logic [15:0] FlagDescriptor = 16'h0008;
   localparam logic [31:0] SizeAllOnes    = 32'hFFFFFFFF;
   localparam int          HeaderLen      = 30;
   localparam int          StoreLen       = HeaderLen - 1;
   localparam logic [16:0] LastHdrPos     = 17'(HeaderLen - 1);
   localparam logic [16:0] LimitReset     = 17'd260;
   localparam logic [7:0]  CharColon      = 8'h3A;
   localparam logic [7:0]  CharDot        = 8'h2E;
   localparam logic [7:0]  CharSlash      = 8'h2F;
   localparam logic [7:0]  CharBackslash  = 8'h5C;

   typedef enum logic [2:0] {
      PhHeader  = 3'd0,
      PhName    = 3'd1,
      PhPayload = 3'd2,
      PhDone    = 3'd3,
      PhBadSig  = 3'd4,
      PhUnsup   = 3'd5,
      PhBadLen  = 3'd6,
      PhBadPath = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      RoleHeader  = 3'd0,
      RoleName    = 3'd1,
      RoleExtra   = 3'd2,
      RolePayload = 3'd3,
      RoleIgnored = 3'd4
   } role_type;

   typedef enum logic [2:0] {
      StatusRunning = 3'd0,
      StatusDone    = 3'd1,
      StatusBadSig  = 3'd2,
      StatusUnsup   = 3'd3,
      StatusBadLen  = 3'd4,
      StatusBadPath = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] signature;
      logic [15:0] flags;
      logic [15:0] method;
      logic [31:0] size;
      logic [15:0] name_size;
      logic [15:0] extra_size;
   } hdr_fields_type;

   typedef struct packed {
      role_type    byte_role;
      logic [7:0]  data_out;
      logic        write_enable;
      logic        entry_open;
      logic        entry_is_directory;
      logic [31:0] entry_size;
      logic        entry_end;
      status_type  status;
      logic [31:0] file_count;
   } result_type;

endpackage

// ===== hdl/zsed_hdr_store.sv =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer header store
// Holds the local header bytes and presents the decoded little-endian fields.
// ----------------------------------------------------------------------------
module zsed_hdr_store (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [4:0]              wr_pos,
   input  logic [7:0]              wr_byte,
   input  logic [7:0]              last_byte,
   output zsed_pkg::hdr_fields_type hdr
);
   import zsed_pkg::*;

   logic [7:0] store_ff [StoreLen];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_pos] <= wr_byte;
      end
   end

   // final header byte is taken straight from the input
   assign hdr.signature  = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
   assign hdr.flags      = {store_ff[7], store_ff[6]};
   assign hdr.method     = {store_ff[9], store_ff[8]};
   assign hdr.size       = {store_ff[21], store_ff[20], store_ff[19], store_ff[18]};
   assign hdr.name_size  = {store_ff[27], store_ff[26]};
   assign hdr.extra_size = {last_byte, store_ff[28]};

endmodule

// ===== hdl/zsed_core.sv =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer core
// Phase machine, name checks, payload countdown and result formation.
// ----------------------------------------------------------------------------
module zsed_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                cfg_write,
   input  logic [16:0]         cfg_data,
   output zsed_pkg::result_type result
);
   import zsed_pkg::*;

   phase_type      phase_ff, phase_in;
   logic [16:0]    pos_ff, pos_in;
   logic [15:0]    name_size_ff, name_size_in;
   logic [15:0]    extra_size_ff, extra_size_in;
   logic [31:0]    remain_ff, remain_in;
   logic [7:0]     prev_ff, prev_in;
   logic           path_bad_ff, path_bad_in;
   logic           is_dir_ff, is_dir_in;
   logic [31:0]    files_ff, files_in;
   logic [16:0]    limit_ff;
   hdr_fields_type hdr;

   logic        hdr_last, hdr_ok, in_name, name_last, char_slash, part_last;
   logic        bad_char;
   logic [17:0] pos_next_wide;
   logic [17:0] part_len;
   logic [31:0] remain_dec;

   zsed_hdr_store u_hdr_store (
      .clock     (clock),
      .wr_en     (accept && phase_ff == PhHeader && pos_ff < 17'(StoreLen)),
      .wr_pos    (pos_ff[4:0]),
      .wr_byte   (in_byte),
      .last_byte (in_byte),
      .hdr       (hdr)
   );

   assign hdr_last      = pos_ff == LastHdrPos;
   assign hdr_ok        = hdr.signature == SigLocal && (hdr.flags & FlagDescriptor) == '0
                          && hdr.method == '0 && hdr.size != SizeAllOnes
                          && hdr.name_size != '0 && {1'b0, hdr.name_size} < limit_ff;
   assign pos_next_wide = {1'b0, pos_ff} + 18'd1;
   assign part_len      = {2'b0, name_size_ff} + {2'b0, extra_size_ff};
   assign in_name       = pos_ff < {1'b0, name_size_ff};
   assign name_last     = pos_next_wide == {2'b0, name_size_ff};
   assign part_last     = pos_next_wide >= part_len;
   assign char_slash    = in_byte == CharSlash || in_byte == CharBackslash;
   assign bad_char      = in_byte == CharColon || (in_byte == CharDot && prev_ff == CharDot)
                          || (pos_ff == '0 && char_slash);
   assign remain_dec    = (remain_ff != '0) ? remain_ff - 32'd1 : '0;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      name_size_in  = name_size_ff;
      extra_size_in = extra_size_ff;
      remain_in     = remain_ff;
      prev_in       = prev_ff;
      path_bad_in   = path_bad_ff;
      is_dir_in     = is_dir_ff;
      files_in      = files_ff;
      case (phase_ff)
         PhHeader: begin
            if (!hdr_last) begin
               pos_in = pos_ff + 17'd1;
            end else begin
               pos_in = '0;
               if (hdr.signature == SigCentral || hdr.signature == SigEnd) begin
                  phase_in = PhDone;
               end else if (hdr.signature != SigLocal) begin
                  phase_in = PhBadSig;
               end else if ((hdr.flags & FlagDescriptor) != '0 || hdr.method != '0
                            || hdr.size == SizeAllOnes) begin
                  phase_in = PhUnsup;
               end else if (!hdr_ok) begin
                  phase_in = PhBadLen;
               end else begin
                  phase_in      = PhName;
                  name_size_in  = hdr.name_size;
                  extra_size_in = hdr.extra_size;
                  remain_in     = hdr.size;
                  prev_in       = '0;
                  path_bad_in   = 1'b0;
                  is_dir_in     = 1'b0;
               end
            end
         end
         PhName: begin
            if (in_name) begin
               path_bad_in = path_bad_ff | bad_char;
               prev_in     = in_byte;
               if (name_last) begin
                  is_dir_in = char_slash;
               end
            end
            if (part_last) begin
               pos_in = '0;
               if (path_bad_in) begin
                  phase_in = PhBadPath;
               end else begin
                  if (!is_dir_in) begin
                     files_in = files_ff + 32'd1;
                  end
                  phase_in = (remain_ff == '0) ? PhHeader : PhPayload;
               end
            end else begin
               pos_in = pos_next_wide[16:0];
            end
         end
         PhPayload: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PhHeader;
               pos_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result                    = '0;
      result.byte_role          = RoleIgnored;
      result.data_out           = in_byte;
      result.file_count         = files_in;
      case (phase_ff)
         PhHeader: begin
            result.byte_role = RoleHeader;
            if (hdr_last && hdr_ok) begin
               result.entry_size = hdr.size;
            end
         end
         PhName: begin
            result.byte_role  = in_name ? RoleName : RoleExtra;
            result.entry_size = hdr.size;
            if (part_last && !path_bad_in) begin
               result.entry_open         = 1'b1;
               result.entry_is_directory = is_dir_in;
               result.entry_end          = remain_ff == '0;
            end
         end
         PhPayload: begin
            result.byte_role    = RolePayload;
            result.entry_size   = hdr.size;
            result.write_enable = !is_dir_ff;
            result.entry_end    = remain_dec == '0;
         end
         default: begin
         end
      endcase
      case (phase_in)
         PhDone:    result.status = StatusDone;
         PhBadSig:  result.status = StatusBadSig;
         PhUnsup:   result.status = StatusUnsup;
         PhBadLen:  result.status = StatusBadLen;
         PhBadPath: result.status = StatusBadPath;
         default:   result.status = StatusRunning;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PhHeader;
         pos_ff        <= '0;
         name_size_ff  <= '0;
         extra_size_ff <= '0;
         remain_ff     <= '0;
         prev_ff       <= '0;
         path_bad_ff   <= 1'b0;
         is_dir_ff     <= 1'b0;
         files_ff      <= '0;
         limit_ff      <= LimitReset;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            pos_ff        <= pos_in;
            name_size_ff  <= name_size_in;
            extra_size_ff <= extra_size_in;
            remain_ff     <= remain_in;
            prev_ff       <= prev_in;
            path_bad_ff   <= path_bad_in;
            is_dir_ff     <= is_dir_in;
            files_ff      <= files_in;
         end
         if (cfg_write) begin
            limit_ff <= cfg_data;
         end
      end
   end

endmodule

// ===== hdl/zsed_out_reg.sv =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer result register
// Holds one result item; refills in the cycle the held item is taken.
// ----------------------------------------------------------------------------
module zsed_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  zsed_pkg::result_type load_data,
   input  logic                out_stall,
   output logic                out_valid,
   output logic                busy,
   output zsed_pkg::result_type out_data
);
   import zsed_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign busy      = valid_ff && out_stall;
   assign valid_in  = load || busy;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ===== hdl/zip_stored_entry_deframer.sv =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer
// Takes a ZIP archive a byte per item, tags each byte and checks each entry.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while the result side does not stall, and its
// result appears in the next cycle from the result register; the phase
// update decodes the header store and checks the name as each byte passes.
// A held result stalls input only while the result side itself stalls.
// Done and errors are sticky until reset; csr_data sets the name length limit.
module zip_stored_entry_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_byte_role,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_write_enable,
   output logic        rsp_entry_open,
   output logic        rsp_entry_is_directory,
   output logic [31:0] rsp_entry_size,
   output logic        rsp_entry_end,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_file_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);
   import zsed_pkg::*;
`include "zip_stored_entry_deframer_macros.svh"

   logic       accept;
   result_type core_result, held;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   zsed_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_data_byte),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_data),
      .result    (core_result)
   );

   zsed_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (core_result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .busy      (req_stall),
      .out_data  (held)
   );

   assign rsp_byte_role          = held.byte_role;
   assign rsp_data_out           = held.data_out;
   assign rsp_write_enable       = held.write_enable;
   assign rsp_entry_open         = held.entry_open;
   assign rsp_entry_is_directory = held.entry_is_directory;
   assign rsp_entry_size         = held.entry_size;
   assign rsp_entry_end          = held.entry_end;
   assign rsp_status             = held.status;
   assign rsp_file_count         = held.file_count;

   `ZSED_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid)
   `ZSED_ASSERT_SAME(a_held_blocks_input, clock, reset, rsp_valid && rsp_stall, req_stall)
   `ZSED_ASSERT_NEXT(a_sticky_ignored, clock, reset,
      rsp_valid && rsp_status != StatusRunning && accept, rsp_byte_role == RoleIgnored)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// ZIP stored-entry deframer testbench
// Builds ZIP archives byte by byte: a short table of hand-made entries, then
// random well-formed entries under several name length limits, and last one
// entry that ends the archive, done or broken in a randomly chosen way,
// followed by bytes that must be ignored. Every result is compared field by
// field with an in-bench copy of the deframer's behaviour.
// ----------------------------------------------------------------------------
module testbench;
   import zsed_pkg::*;

   localparam int HangLimit = 2000;

   typedef enum {ShapePlain, ShapeNul, ShapeDir, ShapeDots, ShapeColon, ShapeLead}
      name_shape_type;

   typedef struct {
      logic [31:0]    sig;
      logic [15:0]    flags;
      logic [15:0]    method;
      logic [31:0]    size;
      int             name_size;
      int             extra_size;
      name_shape_type shape;
      bit             has_typed;
      bit             exp_open;
      bit             exp_dir;
      status_type     exp_status;
   } entry_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_byte_role;
   logic [7:0]  rsp_data_out;
   logic        rsp_write_enable;
   logic        rsp_entry_open;
   logic        rsp_entry_is_directory;
   logic [31:0] rsp_entry_size;
   logic        rsp_entry_end;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_file_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data = 17'd0;

   // deframer state as predicted
   phase_type   dfr_phase;
   logic [7:0]  hdr_store [HeaderLen];
   int unsigned hdr_pos;
   int unsigned name_size_q;
   int unsigned extra_size_q;
   logic [31:0] left_bytes;
   logic [7:0]  prior_char;
   logic        path_flag;
   logic        dir_flag;
   logic [31:0] files_seen;
   logic [16:0] limit_q;

   result_type  expected_q [$];
   int          failures = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   int          gap_quiet = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;
   bit          directed_part = 1'b0;

   entry_row_type directed_rows [7] = '{
      '{SigLocal, 16'h0000, 16'h0000, 32'd0, 1, 0, ShapePlain, 1, 1, 0, StatusRunning},
      '{SigLocal, 16'hFFF7, 16'h0000, 32'd2, 5, 3, ShapeNul, 0, 0, 0, StatusRunning},
      '{SigLocal, 16'h0000, 16'h0000, 32'd3, 4, 0, ShapeDir, 1, 1, 1, StatusRunning},
      '{SigLocal, 16'h0001, 16'h0000, 32'd0, 2, 2, ShapeDir, 1, 1, 1, StatusRunning},
      '{SigLocal, 16'h0000, 16'h0000, 32'd1, 259, 0, ShapePlain, 1, 1, 0, StatusRunning},
      '{SigLocal, 16'h0000, 16'h0000, 32'd1, 1, 4, ShapePlain, 0, 0, 0, StatusRunning},
      '{SigLocal, 16'hFFF7, 16'h0000, 32'd16, 12, 1, ShapeNul, 0, 0, 0, StatusRunning}
   };

   zip_stored_entry_deframer uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_byte_role          (rsp_byte_role),
      .rsp_data_out           (rsp_data_out),
      .rsp_write_enable       (rsp_write_enable),
      .rsp_entry_open         (rsp_entry_open),
      .rsp_entry_is_directory (rsp_entry_is_directory),
      .rsp_entry_size         (rsp_entry_size),
      .rsp_entry_end          (rsp_entry_end),
      .rsp_status             (rsp_status),
      .rsp_file_count         (rsp_file_count),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] hdr_half(input int at);
      return {hdr_store[at + 1], hdr_store[at]};
   endfunction

   function automatic logic [31:0] hdr_word(input int at);
      return {hdr_half(at + 2), hdr_half(at)};
   endfunction

   function automatic void clear_deframer();
      dfr_phase = PhHeader;
      foreach (hdr_store[i]) hdr_store[i] = 8'h00;
      hdr_pos = 0;
      name_size_q = 0;
      extra_size_q = 0;
      left_bytes = '0;
      prior_char = 8'h00;
      path_flag = 1'b0;
      dir_flag = 1'b0;
      files_seen = '0;
      limit_q = LimitReset;
   endfunction

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type  r;
      int unsigned pos;
      logic [31:0] sig;
      r = '0;
      r.byte_role = RoleIgnored;
      r.data_out = b;
      case (dfr_phase)
         PhHeader: begin
            r.byte_role = RoleHeader;
            pos = (hdr_pos >= HeaderLen) ? HeaderLen - 1 : hdr_pos;
            hdr_store[pos] = b;
            if (pos + 1 < HeaderLen) begin
               hdr_pos = pos + 1;
            end else begin
               sig = hdr_word(0);
               hdr_pos = 0;
               if (sig == SigCentral || sig == SigEnd) begin
                  dfr_phase = PhDone;
               end else if (sig != SigLocal) begin
                  dfr_phase = PhBadSig;
               end else if ((hdr_half(6) & FlagDescriptor) != 0 || hdr_half(8) != 0 ||
                            hdr_word(18) == SizeAllOnes) begin
                  dfr_phase = PhUnsup;
               end else if (hdr_half(26) == 0 || {1'b0, hdr_half(26)} >= limit_q) begin
                  dfr_phase = PhBadLen;
               end else begin
                  dfr_phase = PhName;
                  name_size_q = hdr_half(26);
                  extra_size_q = hdr_half(28);
                  left_bytes = hdr_word(18);
                  prior_char = 8'h00;
                  path_flag = 1'b0;
                  dir_flag = 1'b0;
                  r.entry_size = left_bytes;
               end
            end
         end
         PhName: begin
            pos = hdr_pos;
            r.entry_size = hdr_word(18);
            if (pos < name_size_q) begin
               r.byte_role = RoleName;
               if (b == CharColon) path_flag = 1'b1;
               if (b == CharDot && prior_char == CharDot) path_flag = 1'b1;
               if (pos == 0 && (b == CharSlash || b == CharBackslash)) path_flag = 1'b1;
               prior_char = b;
               if (pos + 1 == name_size_q) dir_flag = (b == CharSlash || b == CharBackslash);
            end else begin
               r.byte_role = RoleExtra;
            end
            if (pos + 1 >= name_size_q + extra_size_q) begin
               hdr_pos = 0;
               if (path_flag) begin
                  dfr_phase = PhBadPath;
               end else begin
                  r.entry_open = 1'b1;
                  r.entry_is_directory = dir_flag;
                  if (!dir_flag) files_seen++;
                  if (left_bytes == 0) begin
                     r.entry_end = 1'b1;
                     dfr_phase = PhHeader;
                  end else begin
                     dfr_phase = PhPayload;
                  end
               end
            end else begin
               hdr_pos = pos + 1;
            end
         end
         PhPayload: begin
            r.byte_role = RolePayload;
            r.entry_size = hdr_word(18);
            r.write_enable = !dir_flag;
            if (left_bytes != 0) left_bytes--;
            if (left_bytes == 0) begin
               r.entry_end = 1'b1;
               dfr_phase = PhHeader;
               hdr_pos = 0;
            end
         end
         default: ;
      endcase
      case (dfr_phase)
         PhDone:    r.status = StatusDone;
         PhBadSig:  r.status = StatusBadSig;
         PhUnsup:   r.status = StatusUnsup;
         PhBadLen:  r.status = StatusBadLen;
         PhBadPath: r.status = StatusBadPath;
         default:   r.status = StatusRunning;
      endcase
      r.file_count = files_seen;
      return r;
   endfunction

   // entered just after a rising edge; leaves just after the accepting edge
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (idle_on) begin
         if (gap_quiet > 0) begin
            gap_quiet--;
         end else if ($urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            gap_quiet = $urandom_range(0, 1) ? 0 : $urandom_range(10, 40);
         end
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   task automatic write_limit(input logic [16:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_entry(input entry_row_type e);
      logic [7:0] hdr [HeaderLen];
      logic [7:0] ch;
      logic [7:0] prev;
      result_type last;
      int         mark;
      int         total;
      foreach (hdr[i]) hdr[i] = 8'($urandom);
      {hdr[3], hdr[2], hdr[1], hdr[0]} = e.sig;
      {hdr[7], hdr[6]} = e.flags;
      {hdr[9], hdr[8]} = e.method;
      {hdr[21], hdr[20], hdr[19], hdr[18]} = e.size;
      {hdr[27], hdr[26]} = 16'(e.name_size);
      {hdr[29], hdr[28]} = 16'(e.extra_size);
      for (int k = 0; k < HeaderLen; k++) send_byte(hdr[k]);

      mark = 0;
      if (e.shape == ShapeDots && e.name_size >= 2) mark = $urandom_range(0, e.name_size - 2);
      if (e.shape == ShapeColon && e.name_size >= 1) mark = $urandom_range(0, e.name_size - 1);
      prev = 8'h00;
      total = e.name_size + e.extra_size;
      for (int k = 0; k < total; k++) begin
         ch = 8'($urandom);
         if (k < e.name_size) begin
            if (ch == CharColon) ch = 8'h61;
            if (ch == CharDot && prev == CharDot) ch = 8'h62;
            if (k == 0 && (ch == CharSlash || ch == CharBackslash)) ch = 8'h63;
            if (k == e.name_size - 1 && (ch == CharSlash || ch == CharBackslash)) ch = 8'h64;
            case (e.shape)
               ShapeNul:   if (k == e.name_size / 2) ch = 8'h00;
               ShapeDir:   if (k == e.name_size - 1)
                              ch = $urandom_range(0, 1) ? CharSlash : CharBackslash;
               ShapeDots:  if (k == mark || k == mark + 1) ch = CharDot;
               ShapeColon: if (k == mark) ch = CharColon;
               ShapeLead:  if (k == 0) ch = $urandom_range(0, 1) ? CharSlash : CharBackslash;
               default: ;
            endcase
            prev = ch;
         end
         send_byte(ch);
         if (e.has_typed && k == total - 1) begin
            last = expected_q.pop_back();
            last.entry_open = e.exp_open;
            last.entry_is_directory = e.exp_dir;
            last.status = e.exp_status;
            expected_q.push_back(last);
         end
      end

      if (e.size <= 32'd4096) begin
         for (int k = 0; k < int'(e.size); k++) begin
            if (directed_part) send_byte((k % 2) ? 8'hFF : 8'h00);
            else send_byte(8'($urandom));
         end
      end
   endtask

   function automatic entry_row_type random_entry();
      entry_row_type e;
      int            top;
      top = int'(limit_q) - 1;
      if (top < 1) top = 1;
      e.sig = SigLocal;
      e.flags = 16'($urandom) & ~FlagDescriptor;
      e.method = 16'h0000;
      case ($urandom_range(0, 9))
         0:       e.size = 32'd0;
         1:       e.size = $urandom_range(21, 120);
         default: e.size = $urandom_range(1, 20);
      endcase
      if ($urandom_range(0, 9) == 0) e.name_size = $urandom_range(1, (top < 100) ? top : 100);
      else e.name_size = $urandom_range(1, (top < 12) ? top : 12);
      e.extra_size = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) e.extra_size = $urandom_range(0, 40);
      e.shape = ShapePlain;
      if (e.name_size >= 2 && $urandom_range(0, 4) == 0) e.shape = ShapeDir;
      else if ($urandom_range(0, 7) == 0) e.shape = ShapeNul;
      e.has_typed = 1'b0;
      e.exp_open = 1'b0;
      e.exp_dir = 1'b0;
      e.exp_status = StatusRunning;
      return e;
   endfunction

   task automatic random_run(input int count);
      int mark;
      mark = bytes_sent;
      while (bytes_sent - mark < count) send_entry(random_entry());
   endtask

   // one entry that finishes the archive, one way or another
   task automatic send_closing_entry();
      entry_row_type e;
      e = random_entry();
      case ($urandom_range(0, 11))
         0: e.sig = SigCentral;
         1: e.sig = SigEnd;
         2: e.sig = SigLocal ^ (32'd1 << $urandom_range(0, 31));
         3: e.flags = e.flags | FlagDescriptor;
         4: e.method = 16'($urandom_range(1, 65535));
         5: e.size = SizeAllOnes;
         6: e.name_size = 0;
         7: begin
            write_limit(17'($urandom_range(2, 40)));
            e.name_size = int'(limit_q) + $urandom_range(0, 5);
            e.shape = ShapePlain;
         end
         8: write_limit($urandom_range(0, 1) ? 17'd0 : 17'd1);
         default: begin
            case ($urandom_range(0, 2))
               0:       e.shape = ShapeDots;
               1:       e.shape = ShapeColon;
               default: e.shape = ShapeLead;
            endcase
            e.name_size = $urandom_range(2, 12);
            e.size = $urandom;
            if (e.size == SizeAllOnes) e.size = 32'hFFFFFFFE;
         end
      endcase
      send_entry(e);
      repeat (40) send_byte(8'($urandom));
      send_entry(random_entry());
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", label, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result with no byte outstanding");
            failures++;
         end else begin
            want = expected_q.pop_front();
            check_field("byte_role", want.byte_role, rsp_byte_role);
            check_field("data_out", want.data_out, rsp_data_out);
            check_field("write_enable", want.write_enable, rsp_write_enable);
            check_field("entry_open", want.entry_open, rsp_entry_open);
            check_field("entry_is_directory", want.entry_is_directory,
                        rsp_entry_is_directory);
            check_field("entry_size", want.entry_size, rsp_entry_size);
            check_field("entry_end", want.entry_end, rsp_entry_end);
            check_field("status", want.status, rsp_status);
            check_field("file_count", want.file_count, rsp_file_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= HangLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      clear_deframer();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_part = 1'b1;
      foreach (directed_rows[i]) send_entry(directed_rows[i]);
      directed_part = 1'b0;

      write_limit(17'h1FFFF);
      random_run(20);

      write_limit(17'd65536);
      random_run(20);

      write_limit(17'd2);
      random_run(20);

      write_limit(17'($urandom_range(300, 65536)));
      idle_on = 1'b0;
      random_run(40);
      send_closing_entry();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/zsed_pkg.sv
hdl/zsed_hdr_store.sv
hdl/zsed_core.sv
hdl/zsed_out_reg.sv
hdl/zip_stored_entry_deframer.sv
tb/testbench.sv
